[rtl/mcmp_pkg.sv]
// Shared types and constants for the MIDI channel message parser.
// No dependencies; used by mcmp_core and midi_channel_message_parser_top.
package mcmp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 7;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned EventW = KindW + ChanW + 2 * DataW;
  localparam int unsigned OutW   = ((EventW + 7) / 8) * 8;

  typedef enum logic [KindW-1:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CC       = 3'd2,
    KIND_PB       = 3'd3,
    KIND_PRESSURE = 3'd4,
    KIND_PC       = 3'd5
  } event_kind_t;

  // upper nibble of channel voice status bytes
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CC       = 4'hB;
  localparam logic [3:0] NIB_PC       = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;
  localparam logic [3:0] NIB_PB       = 4'hE;

  localparam logic [ByteW-1:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [ByteW-1:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [ByteW-1:0] BYTE_REALTIME    = 8'hF8;

  typedef struct packed {
    logic              hit;
    event_kind_t       kind;
    logic [ChanW-1:0]  channel;
    logic [DataW-1:0]  first_data;
    logic [DataW-1:0]  second_data;
  } mcmp_event_t;

endpackage

[rtl/midi_channel_message_parser_top.sv]
// MIDI channel message parser: input byte register, mcmp_core, event register.
// Depends on mcmp_pkg and mcmp_core.
//
//   channel   dir  tdata (low bit up)                                  width
//   s_axis    in   byte_in[7:0]                                        8
//   m_axis    out  event_kind[2:0] channel[6:3] first_data[13:7]       24
//                  second_data[20:14], zero fill [23:21]
//
// One byte per cycle is sustained while m_axis is not stalled; a byte waits in the input
// register and its event, if any, is loaded into the output register as the byte leaves.
// The parser state updates when the byte leaves the input register, which
// happens only when the output register is empty or being drained.
// Sync reset clears the parser control state and both valid flags.
// A stalled m_axis holds its word; s_axis stalls only once the input register
// is full behind it.
module midi_channel_message_parser_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mcmp_pkg::ByteW-1:0]   s_axis_tdata,   // byte_in
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mcmp_pkg::OutW-1:0]    m_axis_tdata    // event_kind, channel,
                                                        // first_data, second_data
);
  import mcmp_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             advance;
  mcmp_event_t      evt;
  mcmp_event_t      out_evt;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  mcmp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .evt     (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= evt.hit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.hit) begin
      out_evt <= evt;
    end
  end

  assign m_axis_tdata = {{(OutW - EventW){1'b0}}, out_evt.second_data,
                         out_evt.first_data, out_evt.channel, out_evt.kind};

  // held input byte must not be lost while the core is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input register overwritten while stalled");

  a_note_on_vel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_evt.kind == KIND_NOTE_ON |-> out_evt.second_data != '0)
    else $error("note-on with zero velocity");

  a_one_byte_msg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_evt.kind == KIND_PC || out_evt.kind == KIND_PRESSURE)
    |-> out_evt.second_data == '0)
    else $error("one-byte message with nonzero second data");

  // an event reaches the output only from a byte that advanced last cycle
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance))
    else $error("event appeared without a processed byte");

endmodule

[rtl/mcmp_core.sv]
// Parser state (running status, SysEx flag, data collection) and byte decode.
// Depends on mcmp_pkg. Event output is combinational from state, byte and step.
module mcmp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [mcmp_pkg::ByteW-1:0]   byte_in,
  output mcmp_pkg::mcmp_event_t        evt
);
  import mcmp_pkg::*;

  logic             sysex_active, sysex_active_next;
  logic             rs_valid, rs_valid_next;
  logic [ByteW-1:0] running_status, running_status_next;
  logic             need_two, need_two_next;
  logic             bytes_held, bytes_held_next;
  logic [DataW-1:0] data_store, data_store_next;

  logic [3:0]       rs_nib;
  logic [DataW-1:0] d1, d2;

  assign rs_nib = running_status[7:4];

  always_comb begin
    sysex_active_next   = sysex_active;
    rs_valid_next       = rs_valid;
    running_status_next = running_status;
    need_two_next       = need_two;
    bytes_held_next     = bytes_held;
    data_store_next     = data_store;
    d1                  = bytes_held ? data_store : byte_in[DataW-1:0];
    d2                  = need_two ? byte_in[DataW-1:0] : '0;
    evt                 = '0;
    evt.channel         = running_status[ChanW-1:0];
    evt.first_data      = d1;
    evt.second_data     = d2;

    priority if (byte_in >= BYTE_REALTIME) begin
      // realtime: no effect, even inside SysEx
    end else if (byte_in == BYTE_SYSEX_START) begin
      sysex_active_next = 1'b1;
      rs_valid_next     = 1'b0;
    end else if (byte_in == BYTE_SYSEX_END) begin
      sysex_active_next = 1'b0;
    end else if (sysex_active) begin
      // skipped SysEx payload
    end else if (byte_in >= BYTE_SYSEX_START) begin
      rs_valid_next = 1'b0;
    end else if (byte_in[7]) begin
      rs_valid_next       = 1'b1;
      running_status_next = byte_in;
      need_two_next       = !(byte_in[7:4] == NIB_PC || byte_in[7:4] == NIB_PRESSURE);
      bytes_held_next     = 1'b0;
    end else if (rs_valid) begin
      if (!bytes_held && need_two) begin
        bytes_held_next = 1'b1;
        data_store_next = byte_in[DataW-1:0];
      end else begin
        bytes_held_next = 1'b0;
        if (!bytes_held) data_store_next = byte_in[DataW-1:0];
        evt.hit = step;
        unique case (rs_nib)
          NIB_NOTE_ON:  evt.kind = (d2 != '0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
          NIB_NOTE_OFF: evt.kind = KIND_NOTE_OFF;
          NIB_CC:       evt.kind = KIND_CC;
          NIB_PB:       evt.kind = KIND_PB;
          NIB_PRESSURE: evt.kind = KIND_PRESSURE;
          NIB_PC:       evt.kind = KIND_PC;
          default: begin
            // poly aftertouch completes with no event
            evt.hit  = 1'b0;
            evt.kind = KIND_NOTE_OFF;
          end
        endcase
      end
    end else begin
      // data byte with no running status: dropped
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sysex_active <= 1'b0;
      rs_valid     <= 1'b0;
      need_two     <= 1'b0;
      bytes_held   <= 1'b0;
    end else if (step) begin
      sysex_active <= sysex_active_next;
      rs_valid     <= rs_valid_next;
      need_two     <= need_two_next;
      bytes_held   <= bytes_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      running_status <= running_status_next;
      data_store     <= data_store_next;
    end
  end

endmodule

[tb/tb_midi_channel_message_parser_top.sv]
// Self-checking testbench for midi_channel_message_parser_top.
// Depends on mcmp_pkg and the parser RTL; predicts each event, checks it on m_axis.
module tb_midi_channel_message_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcmp_pkg::*;

  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int ByteTarget    = 550;

  localparam logic [ByteW-1:0] BYTE_SONG_SELECT  = 8'hF3;
  localparam logic [ByteW-1:0] BYTE_TUNE_REQUEST = 8'hF6;
  localparam logic [ByteW-1:0] BYTE_RESET        = 8'hFF;
  localparam logic [ByteW-1:0] BYTE_COMMON_FIRST = 8'hF1;

  typedef struct packed {
    event_kind_t       kind;
    logic [ChanW-1:0]  channel;
    logic [DataW-1:0]  first_data;
    logic [DataW-1:0]  second_data;
  } midi_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ByteW-1:0]  s_axis_tdata = '0;   // byte_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutW-1:0]   m_axis_tdata;        // event_kind, channel, first_data, second_data

  midi_channel_message_parser_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser shadow state
  logic              shadow_sysex = 1'b0;
  logic [ByteW-1:0]  cur_status = '0;
  logic [1:0]        data_needed = '0;
  logic              have_first = 1'b0;
  logic [DataW-1:0]  held_data [2] = '{default: '0};

  midi_event_t pending_events [$];
  int  bytes_sent   = 0;
  int  events_seen  = 0;
  int  mismatches   = 0;
  int  stuck_cycles = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;
  bit  hold_req     = 1'b0;

  // Runs one byte through the shadow parser; returns 1 when a voice event completes.
  function automatic bit decode_midi_byte(input logic [ByteW-1:0] b, output midi_event_t ev);
    logic [DataW-1:0] d2;
    ev = '0;
    if (b >= BYTE_REALTIME) return 1'b0;
    if (b == BYTE_SYSEX_START) begin
      shadow_sysex = 1'b1;
      cur_status   = '0;
      return 1'b0;
    end
    if (b == BYTE_SYSEX_END) begin
      shadow_sysex = 1'b0;
      return 1'b0;
    end
    if (shadow_sysex) return 1'b0;
    if (b >= BYTE_SYSEX_START) begin
      cur_status = '0;
      return 1'b0;
    end
    if (b[7]) begin
      cur_status  = b;
      data_needed = (b[7:4] == NIB_PC || b[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
      have_first  = 1'b0;
      return 1'b0;
    end
    if (cur_status == '0) return 1'b0;
    held_data[have_first] = b[DataW-1:0];
    if (!have_first && data_needed >= 2'd2) begin
      have_first = 1'b1;
      return 1'b0;
    end
    have_first     = 1'b0;
    d2             = (data_needed > 2'd1) ? held_data[1] : '0;
    ev.channel     = cur_status[3:0];
    ev.first_data  = held_data[0];
    ev.second_data = d2;
    case (cur_status[7:4])
      NIB_NOTE_ON:  ev.kind = (d2 != '0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
      NIB_NOTE_OFF: ev.kind = KIND_NOTE_OFF;
      NIB_CC:       ev.kind = KIND_CC;
      NIB_PB:       ev.kind = KIND_PB;
      NIB_PRESSURE: ev.kind = KIND_PRESSURE;
      NIB_PC:       ev.kind = KIND_PC;
      default:      return 1'b0;   // poly aftertouch completes silently
    endcase
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    midi_event_t ev;
    while (tx_idle_on && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (decode_midi_byte(b, ev)) pending_events.push_back(ev);
  endtask

  task automatic send_list(input logic [ByteW-1:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // data bytes for one message under status st, with an occasional realtime byte; zero second data now and then
  task automatic send_message_data(input logic [ByteW-1:0] st);
    int count;
    logic [ByteW-1:0] d;
    count = (st[7:4] == NIB_PC || st[7:4] == NIB_PRESSURE) ? 1 : 2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) send_byte(8'($urandom_range(BYTE_REALTIME, BYTE_RESET)));
      d = 8'($urandom_range(127));
      if (i == 1 && $urandom_range(7) == 0) d = '0;
      send_byte(d);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(posedge clk);
      end else begin
        m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin
    midi_event_t exp_ev;
    event_kind_t got_kind;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      events_seen++;
      got_kind = event_kind_t'(m_axis_tdata[2:0]);
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        exp_ev = pending_events.pop_front();
        if (got_kind != exp_ev.kind || m_axis_tdata[6:3] != exp_ev.channel ||
            m_axis_tdata[13:7] != exp_ev.first_data ||
            m_axis_tdata[20:14] != exp_ev.second_data)
          note_mismatch($sformatf(
            "exp kind %0d ch %0d d1 %0d d2 %0d, got kind %0d ch %0d d1 %0d d2 %0d",
            exp_ev.kind, exp_ev.channel, exp_ev.first_data, exp_ev.second_data,
            m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[13:7],
            m_axis_tdata[20:14]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("timeout: no word moved for %0d cycles", stuck_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // every voice kind, field extremes, running status, zero velocity, stray data
  task automatic test_voice_messages();
    send_list('{8'h00, {NIB_NOTE_ON, 4'h0}, 8'h3C, 8'h64, 8'h3C, 8'h00,
                {NIB_NOTE_OFF, 4'hF}, 8'h7F, 8'h7F,
                {NIB_POLY_AT, 4'h5}, 8'h10, 8'h20,
                {NIB_CC, 4'h3}, 8'h07, 8'h00,
                {NIB_PC, 4'h2}, 8'h05, 8'h06,
                {NIB_PRESSURE, 4'h1}, 8'h40,
                {NIB_PB, 4'h4}, 8'h7F, 8'h00});
  endtask

  // realtime mid-message, sysex swallowing status, lone sysex end, system common
  task automatic test_system_bytes();
    send_list('{{NIB_NOTE_ON, 4'hE}, 8'h01, BYTE_REALTIME, 8'h02,
                BYTE_SYSEX_START, {NIB_NOTE_ON, 4'h9}, BYTE_RESET, BYTE_SYSEX_END, 8'h03,
                {NIB_CC, 4'h2}, BYTE_SYSEX_END, 8'h04, 8'h05,
                BYTE_SONG_SELECT, 8'h12, BYTE_TUNE_REQUEST});
  endtask

  // long receiver hold-off while note traffic keeps coming; input must stall
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    send_byte({NIB_NOTE_ON, 4'hA});
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(1, 127)));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int pick;
    int count;
    logic [ByteW-1:0] st;
    logic [ByteW-1:0] b;
    while (bytes_sent < ByteTarget) begin
      tx_idle_on = !(bytes_sent >= 250 && bytes_sent < 350);
      rx_idle_on = tx_idle_on;
      pick = $urandom_range(99);
      st   = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
      if (pick < 70) begin
        send_byte(st);
        count = $urandom_range(1, 3);
        repeat (count) send_message_data(st);
      end else if (pick < 78) begin
        send_byte(8'($urandom_range(BYTE_REALTIME, BYTE_RESET)));
      end else if (pick < 84) begin
        send_byte(BYTE_SYSEX_START);
        count = $urandom_range(4);
        repeat (count) begin
          b = 8'($urandom);
          if (b == BYTE_SYSEX_END) b = '0;
          send_byte(b);
        end
        if ($urandom_range(9) != 0) send_byte(BYTE_SYSEX_END);
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(BYTE_COMMON_FIRST, BYTE_TUNE_REQUEST)));
      end else if (pick < 95) begin
        send_byte(8'($urandom_range(127)));
      end else begin
        // message cut short by the next status
        send_byte(st);
        send_byte(8'($urandom_range(127)));
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_voice_messages();
    test_system_bytes();
    test_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("summary: %0d bytes in (voice, running status, realtime, sysex, system common,",
             bytes_sent);
    $display("summary: stray data, long output stall), %0d events checked, %0d mismatches",
             events_seen, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
